// ===== design/crcl_pkg.sv =====
// Shared types, constants and matrix helpers for the byte-lane CRC-32 block.
package crcl_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam int          DATA_BYTES = 8;
    localparam int          CNT_W      = 4;

    typedef struct packed {
        logic [63:0]      data_bytes;
        logic [CNT_W-1:0] byte_count;
        logic             start_of_message;
        logic             end_of_message;
    } crcl_word_t;

    typedef struct packed {
        logic [31:0] crc_value;
        logic        message_done;
    } crcl_result_t;

    // Lane stage to state stage: merged data term and per-word control.
    typedef struct packed {
        logic [31:0]      partial;
        logic [CNT_W-1:0] count;
        logic             start;
        logic             last;
    } crcl_stage_t;

    // Run a unit vector through nbits zero-data shift steps (one matrix column).
    function automatic logic [31:0] adv_col(input int nbits, input int pos);
        logic [31:0] r;
        r = 32'd1 << pos;
        for (int k = 0; k < nbits; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Row of the nbits-step matrix: which input bits feed output bit out_bit.
    function automatic logic [31:0] row_mask(input int nbits, input int out_bit,
                                             input int in_bits);
        logic [31:0] m;
        logic [31:0] col;
        m = '0;
        for (int i = 0; i < in_bits; i++)
        begin
            col  = adv_col(nbits, i);
            m[i] = col[out_bit];
        end
        return m;
    endfunction

endpackage

// ===== design/crcl_lane.sv =====
// One byte lane: CRC contribution of a byte followed by a fixed number of bytes.
module crcl_lane #(
    parameter int TRAIL = 0
) (
    input  logic [7:0]  lane_byte,
    output logic [31:0] contrib
);

    for (genvar o = 0; o < 32; o++)
    begin : g_bit
        localparam logic [31:0] MASK = crcl_pkg::row_mask(8 * (TRAIL + 1), o, 8);
        assign contrib[o] = ^(lane_byte & MASK[7:0]);
    end

endmodule

// ===== design/crcl_advance.sv =====
// Advance a CRC register over a fixed number of zero bytes (XOR matrix).
module crcl_advance #(
    parameter int NBYTES = 0
) (
    input  logic [31:0] crc_in,
    output logic [31:0] crc_out
);

    for (genvar o = 0; o < 32; o++)
    begin : g_bit
        localparam logic [31:0] MASK = crcl_pkg::row_mask(8 * NBYTES, o, 32);
        assign crc_out[o] = ^(crc_in & MASK);
    end

endmodule

// ===== design/crcl_state.sv =====
// Running CRC register: reload from seed, advance by byte count, fold in data term.
module crcl_state #(
    parameter int NL = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  crcl_pkg::crcl_stage_t  stage,
    input  logic [31:0]            seed,
    output logic [31:0]            running_crc
);

    localparam int NLW = $clog2(NL + 1);

    logic [31:0] running_crc_reg;
    logic [31:0] running_crc_next;
    logic [31:0] base;
    logic [31:0] adv [NL+1];

    assign base = stage.start ? ~seed : running_crc_reg;

    for (genvar k = 0; k <= NL; k++)
    begin : g_adv
        crcl_advance #(.NBYTES(k)) u_adv (
            .crc_in  (base),
            .crc_out (adv[k])
        );
    end

    always_comb
    begin
        running_crc_next = running_crc_reg;
        if (advance)
        begin
            running_crc_next = adv[stage.count[NLW-1:0]] ^ stage.partial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= 32'hFFFFFFFF;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
        end
    end

    assign running_crc = running_crc_reg;

endmodule

// ===== design/crc32_byte_lanes_top.sv =====
// Top level of the byte-lane CRC-32 (reflected, poly 0xEDB88320) engine.
//
//   channel   dir  handshake                    payload
//   word      in   word_valid / word_stall      crcl_word_t   (data, count, start, end)
//   result    out  result_valid / result_stall  crcl_result_t (crc_value, message_done)
//   seed      in   seed_crc_wen                 seed_crc_wdata (32 bits, no read-back)
//
// One word per clock while result_stall is low; results come from a result register.
// Stage one aligns the valid bytes to the top lane and XORs the lane terms;
// stage two is the running-CRC feedback (one zero-byte matrix per count).
// Reset clears the pipeline valids, the seed to 0 and the running CRC to all ones.
// A stalled result holds; stage one keeps taking a word while the result waits
// and raises word_stall only when both stages are full.
module crc32_byte_lanes_top #(
    parameter int LANES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_stall,
    input  crcl_pkg::crcl_word_t   word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output crcl_pkg::crcl_result_t result,
    input  logic                   seed_crc_wen,
    input  logic [31:0]            seed_crc_wdata
);

    // Lanes beyond the eight bytes a word carries would see no data.
    localparam int NL = (LANES < crcl_pkg::DATA_BYTES) ? LANES : crcl_pkg::DATA_BYTES;
    localparam logic [crcl_pkg::CNT_W-1:0] CNT_MAX = crcl_pkg::CNT_W'(NL);

    logic                    accept;
    logic                    s1_adv;
    logic [crcl_pkg::CNT_W-1:0] cnt_sat;
    logic [crcl_pkg::CNT_W-1:0] shamt;
    logic [NL*8-1:0]         window;
    logic [31:0]             lane_term [NL];
    logic [31:0]             merged;
    logic [31:0]             running_crc;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    crcl_pkg::crcl_stage_t   s1_reg;
    crcl_pkg::crcl_stage_t   s1_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    done_reg;
    logic                    done_next;
    logic [31:0]             seed_crc_reg;
    logic [31:0]             seed_crc_next;

    // Stall upstream only when stage one is full and cannot drain.
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign word_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign accept     = word_valid && !word_stall;

    // Clamp the count, then push the valid bytes up against the top lane so that
    // each lane's trailing-byte distance is fixed. Leading empty lanes are zero,
    // which leaves a zero-start CRC unchanged.
    assign cnt_sat = (word.byte_count > CNT_MAX) ? CNT_MAX : word.byte_count;
    assign shamt   = CNT_MAX - cnt_sat;
    assign window  = word.data_bytes[NL*8-1:0] << {shamt, 3'b000};

    for (genvar j = 0; j < NL; j++)
    begin : g_lane
        crcl_lane #(.TRAIL(NL - 1 - j)) u_lane (
            .lane_byte (window[8*j +: 8]),
            .contrib   (lane_term[j])
        );
    end

    // Merge: lanes are linear, so their terms simply XOR.
    always_comb
    begin
        merged = '0;
        for (int j = 0; j < NL; j++)
        begin
            merged = merged ^ lane_term[j];
        end
    end

    always_comb
    begin
        s1_next         = s1_reg;
        s1_valid_next   = s1_valid_reg;
        if (accept)
        begin
            s1_next.partial = merged;
            s1_next.count   = cnt_sat;
            s1_next.start   = word.start_of_message;
            s1_next.last    = word.end_of_message;
            s1_valid_next   = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        done_next      = done_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            done_next      = s1_reg.last;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign seed_crc_next = seed_crc_wen ? seed_crc_wdata : seed_crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_crc_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            seed_crc_reg  <= seed_crc_next;
        end
    end

    // Payload holds without reset.
    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        done_reg <= done_next;
    end

    // Running CRC advances exactly when a word moves into the result register,
    // so the held result always matches the register.
    crcl_state #(.NL(NL)) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_adv),
        .stage       (s1_reg),
        .seed        (seed_crc_reg),
        .running_crc (running_crc)
    );

    assign result_valid        = out_valid_reg;
    assign result.crc_value    = ~running_crc;
    assign result.message_done = done_reg;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |-> (s1_valid_reg && result_valid && result_stall))
        else $error("word_stall raised while pipeline can drain");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !word_stall)
        else $error("word_stall raised with stage one empty");

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> result_valid)
        else $error("stage one advanced but no result presented");

    a_seed_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.start && (s1_reg.count == '0))
            |=> (result.crc_value == $past(seed_crc_reg)))
        else $error("empty start word did not return the seed");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the byte-lane CRC-32 engine crc32_byte_lanes_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES        = 8;
    localparam int DRAIN_CYCLES = 8;   // pipeline is two deep; leave margin
    localparam int HOLD_CYCLES  = 200; // long receiver hold-off

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   word_valid     = 1'b0;
    logic                   word_stall;
    crcl_pkg::crcl_word_t   word           = '0;
    logic                   result_valid;
    logic                   result_stall   = 1'b0;
    crcl_pkg::crcl_result_t result;
    logic                   seed_crc_wen   = 1'b0;
    logic [31:0]            seed_crc_wdata = '0;

    // Words waiting to be offered, and results predicted but not yet seen.
    crcl_pkg::crcl_word_t   pending_words[$];
    crcl_pkg::crcl_result_t crc_expect_q[$];

    // Predictor state: running register (before final inversion) and seed copy.
    logic [31:0]  crc_running   = 32'hFFFF_FFFF;
    logic [31:0]  crc_seed_model = '0;

    // Idle percentages per side, set by the stimulus between phases.
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;

    // Long receiver hold-off: requested by the stimulus, timed by its own process.
    logic         long_hold_go   = 1'b0;
    logic         long_hold_done = 1'b0;
    int unsigned  long_hold_cnt  = 0;

    int unsigned  error_count        = 0;
    int unsigned  words_accepted     = 0;
    int unsigned  results_checked    = 0;
    int unsigned  messages_started   = 0;
    int unsigned  messages_finished  = 0;
    int unsigned  input_stall_cycles = 0;

    crc32_byte_lanes_top #(
        .LANES(LANES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .word          (word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .seed_crc_wen  (seed_crc_wen),
        .seed_crc_wdata(seed_crc_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the running register over one word: reload from the inverted
    // seed on a start flag, then absorb the valid bytes low lane first, LSB
    // first. Counts above the lane count (or above eight) saturate.
    function automatic logic [31:0] crc_fold_word(input logic [31:0]          run,
                                                  input logic [31:0]          seed,
                                                  input crcl_pkg::crcl_word_t w);
        int          n;
        logic [31:0] r;
        n = w.byte_count;
        if (n > LANES)
            n = LANES;
        if (n > 8)
            n = 8;
        r = run;
        if (w.start_of_message)
            r = ~seed;
        for (int i = 0; i < n; i++)
        begin
            r = r ^ {24'd0, w.data_bytes[8*i +: 8]};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
        end
        return r;
    endfunction

    // Byte count mix: mostly full words, some short, a few zero or oversized.
    function automatic logic [3:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 4'd8;
        else if (roll < 88)
            return 4'($urandom_range(7, 1));
        else if (roll < 94)
            return 4'd0;
        else
            return 4'($urandom_range(15, 9));
    endfunction

    // Driver: on acceptance, run the word through the predictor and queue its
    // result; then present the next word unless the sender idles this cycle.
    // A stalled word is held untouched.
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        crcl_pkg::crcl_result_t predicted;
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            word       <= '0;
        end
        else
        begin
            if (word_valid && word_stall)
                input_stall_cycles++;
            if (word_valid && !word_stall)
            begin
                crc_running            = crc_fold_word(crc_running, crc_seed_model, word);
                predicted.crc_value    = ~crc_running;
                predicted.message_done = word.end_of_message;
                crc_expect_q.push_back(predicted);
                words_accepted++;
                if (word.start_of_message)
                    messages_started++;
            end
            if (!word_valid || !word_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word       <= pending_words.pop_front();
                    word_valid <= 1'b1;
                end
                else
                begin
                    word_valid <= 1'b0;
                end
            end
        end
    end

    // Time the long hold-off once it is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_cnt  <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_go && !long_hold_done)
        begin
            if (long_hold_cnt == HOLD_CYCLES - 1)
                long_hold_done <= 1'b1;
            long_hold_cnt <= long_hold_cnt + 1;
        end
    end

    // Monitor: check each accepted result against the oldest prediction,
    // then choose next cycle's stall.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        crcl_pkg::crcl_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (crc_expect_q.size() == 0)
                begin
                    $error("result with no word outstanding: crc_value %h message_done %b",
                           result.crc_value, result.message_done);
                    error_count++;
                end
                else
                begin
                    want = crc_expect_q.pop_front();
                    results_checked++;
                    if (result.message_done)
                        messages_finished++;
                    if (result.crc_value !== want.crc_value)
                    begin
                        $error("crc_value mismatch: expected %h, got %h",
                               want.crc_value, result.crc_value);
                        error_count++;
                    end
                    if (result.message_done !== want.message_done)
                    begin
                        $error("message_done mismatch: expected %b, got %b",
                               want.message_done, result.message_done);
                        error_count++;
                    end
                end
            end
            result_stall <= (long_hold_go && !long_hold_done) ||
                            ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_word(input logic [63:0] data, input logic [3:0] count,
                             input logic sop, input logic eop);
        crcl_pkg::crcl_word_t w;
        w.data_bytes       = data;
        w.byte_count       = count;
        w.start_of_message = sop;
        w.end_of_message   = eop;
        pending_words.push_back(w);
    endtask

    // Hold until the block is empty: nothing queued, nothing on the wire,
    // nothing outstanding; then let the pipeline settle.
    task automatic wait_drained();
        while (pending_words.size() != 0 || word_valid || crc_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the seed register while the block is idle and update the copy.
    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        seed_crc_wen   <= 1'b1;
        seed_crc_wdata <= value;
        @(posedge clk);
        seed_crc_wen   <= 1'b0;
        @(negedge clk);
        crc_seed_model = value;
    endtask

    // Queue about n_words of traffic: mostly well-formed messages of one to
    // six words with random content, the rest loose words with random flags.
    task automatic queue_traffic(input int n_words);
        int queued;
        int len;
        queued = 0;
        while (queued < n_words)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    push_word({$urandom, $urandom}, pick_count(), i == 0, i == len - 1);
                queued += len;
            end
            else
            begin
                push_word({$urandom, $urandom}, 4'($urandom_range(15)),
                          1'($urandom), 1'($urandom));
                queued++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words, reset seed of zero, no idling.
        // First word carries no start flag: it continues from the reset register.
        push_word(64'h0000_0000_A5C3_0F81, 4'd4, 1'b0, 1'b0);
        // The standard check string "123456789" over two words.
        push_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0);
        push_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1);
        // Extremes of the data field.
        push_word(64'h0, 4'd8, 1'b1, 1'b1);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1);
        // Zero count: reload only, then a zero-count word that only reports.
        push_word({$urandom, $urandom}, 4'd0, 1'b1, 1'b0);
        push_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b1);
        // Counts above the lane count saturate.
        push_word({$urandom, $urandom}, 4'd9, 1'b1, 1'b0);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b1);
        // Keep running past an end mark without a new start.
        push_word({$urandom, $urandom}, 4'd3, 1'b0, 1'b1);
        // Every short count, start flag alternating.
        for (int c = 1; c < 8; c++)
            push_word({$urandom, $urandom}, 4'(c), 1'(c % 2), 1'(c == 7));
        // "12345" as a message of its own.
        push_word(64'h0000_0035_3433_3231, 4'd5, 1'b1, 1'b1);
        wait_drained();

        // Continue "12345" with "6789" from its CRC as seed.
        write_seed(~crc_running);
        push_word(64'h0000_0000_3938_3736, 4'd4, 1'b1, 1'b1);
        wait_drained();

        // Phase A: zero seed, sender idles lightly, receiver heavily.
        write_seed(32'h0000_0000);
        push_word(64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b1);
        send_idle_pct = 24;
        recv_idle_pct = 71;
        queue_traffic(65);
        // Pause the sender until every result has come back.
        wait_drained();
        queue_traffic(65);
        wait_drained();

        // Phase B: all-ones seed, idling swapped.
        write_seed(32'hFFFF_FFFF);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1);
        send_idle_pct = 71;
        recv_idle_pct = 24;
        queue_traffic(130);
        wait_drained();

        // Phase C: seed carried from the last CRC, no idling. Hold the
        // receiver off for a long stretch while words keep coming so the
        // pipeline fills and the input stalls.
        write_seed(~crc_running);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_traffic(100);
        long_hold_go = 1'b1;
        wait_drained();

        // Phase D: random seed, no idling.
        write_seed($urandom);
        queue_traffic(40);
        wait_drained();

        $display("covered %0d words (%0d starts, %0d ends) under seeds zero, all ones,",
                 words_accepted, messages_started, messages_finished);
        $display("carried and random; %0d results checked, input stalled %0d cycles",
                 results_checked, input_stall_cycles);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
